@@ hdl/skt_pkg.sv @@
// skt_pkg: shared sizes, codes and structs for the sorted key table.
// Used by skt_ctrl and sorted_key_table; no dependencies.
package skt_pkg;

	localparam int DEPTH     = 64;
	localparam int KEY_BYTES = 8;

	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 32;
	localparam int ENTRY_W  = KEY_W + HANDLE_W;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int PORT_W   = 7;
	localparam int CAP_W    = 7;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// only the leading KEY_BYTES bytes of a key take part
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << ((8 - KEY_BYTES) * 8);

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd5;

	typedef struct packed {
		logic               re;
		logic [ADDR_W-1:0]  raddr;
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [ENTRY_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PORT_W-1:0]   position;
		logic [HANDLE_W-1:0] stored_handle;
		logic [PORT_W-1:0]   entry_count;
	} result_t;

endpackage

@@ hdl/skt_ram.sv @@
// skt_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module skt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/skt_ctrl.sv @@
// skt_ctrl: request sequencer - binary search over the entry RAM, then
// an entry-by-entry shift for insert and remove. Depends on skt_pkg.
module skt_ctrl import skt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [KEY_W-1:0]    key,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [CAP_W-1:0]    capacity,
	output mem_req_t            mem_req,
	input  logic [ENTRY_W-1:0]  mem_rdata,
	output logic                res_valid,
	input  logic                res_ready,
	output result_t             res
);

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_CMP, S_DECIDE, S_SHIFT, S_DONE
	} state_t;

	state_t              state_q;
	logic [MODE_W-1:0]   mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [CNT_W-1:0]    lo_q, hi_q, occ_q, rem_q;
	logic [ADDR_W-1:0]   mid_q, rd_q, wa_q;
	logic                hit_q, pend_q, ins_q;
	logic [HANDLE_W-1:0] got_q;
	result_t             res_q;

	logic [CNT_W-1:0]    mid_c, occ_m1, lo_p1;
	logic [KEY_W-1:0]    rkey;
	logic [HANDLE_W-1:0] rhandle;
	logic                full;

	assign mid_c   = lo_q + ((hi_q - lo_q) >> 1);
	assign occ_m1  = occ_q - CNT_W'(1);
	assign lo_p1   = lo_q + CNT_W'(1);
	assign rkey    = mem_rdata[ENTRY_W-1 -: KEY_W];
	assign rhandle = mem_rdata[HANDLE_W-1:0];
	assign full    = (occ_q >= CNT_W'(DEPTH)) || (32'(occ_q) >= 32'(capacity));

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		mem_req = '0;
		case (state_q)
			S_SEARCH: begin
				if (lo_q < hi_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = mid_c[ADDR_W-1:0];
				end
			end
			S_SHIFT: begin
				if (rem_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_q;
				end
				if (pend_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = wa_q;
					mem_req.wdata = mem_rdata;
				end else if (rem_q == '0 && ins_q) begin
					// all moves landed: drop the new word into the gap
					mem_req.we    = 1'b1;
					mem_req.waddr = lo_q[ADDR_W-1:0];
					mem_req.wdata = {key_q, handle_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q   <= mode;
						key_q    <= key & KEY_MASK;
						handle_q <= handle;
						lo_q     <= '0;
						hi_q     <= occ_q;
						hit_q    <= 1'b0;
						got_q    <= '0;
						state_q  <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_c[ADDR_W-1:0];
						state_q <= S_CMP;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_CMP: begin
					if (rkey < key_q) begin
						lo_q <= CNT_W'(mid_q) + CNT_W'(1);
					end else begin
						// last upper-bound move is the lower-bound entry itself
						hi_q  <= CNT_W'(mid_q);
						hit_q <= (rkey == key_q);
						got_q <= rhandle;
					end
					state_q <= S_SEARCH;
				end
				S_DECIDE: begin
					res_q.position      <= PORT_W'(lo_q);
					res_q.stored_handle <= '0;
					res_q.entry_count   <= PORT_W'(occ_q);
					pend_q              <= 1'b0;
					state_q             <= S_DONE;
					case (mode_q)
						MODE_INSERT: begin
							if (full) begin
								res_q.status <= STAT_FULL;
							end else if (hit_q) begin
								res_q.status <= STAT_DUPLICATE;
							end else begin
								res_q.status      <= STAT_INSERTED;
								res_q.entry_count <= PORT_W'(occ_q + CNT_W'(1));
								occ_q             <= occ_q + CNT_W'(1);
								ins_q             <= 1'b1;
								rem_q             <= occ_q - lo_q;
								rd_q              <= occ_m1[ADDR_W-1:0];
								state_q           <= S_SHIFT;
							end
						end
						MODE_REMOVE: begin
							if (hit_q) begin
								res_q.status        <= STAT_REMOVED;
								res_q.stored_handle <= got_q;
								res_q.entry_count   <= PORT_W'(occ_m1);
								occ_q               <= occ_m1;
								ins_q               <= 1'b0;
								rem_q               <= occ_m1 - lo_q;
								rd_q                <= lo_p1[ADDR_W-1:0];
								state_q             <= S_SHIFT;
							end else begin
								res_q.status <= STAT_NOT_FOUND;
							end
						end
						default: begin
							if (hit_q) begin
								res_q.status        <= STAT_FOUND;
								res_q.stored_handle <= got_q;
							end else begin
								res_q.status <= STAT_NOT_FOUND;
							end
						end
					endcase
				end
				S_SHIFT: begin
					// one move per cycle: read here, write one step over next cycle
					if (rem_q != '0) begin
						rem_q  <= rem_q - CNT_W'(1);
						rd_q   <= ins_q ? rd_q - ADDR_W'(1) : rd_q + ADDR_W'(1);
						wa_q   <= ins_q ? rd_q + ADDR_W'(1) : rd_q - ADDR_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/sorted_key_table.sv @@
// Channel  Handshake              Word
// in       in_valid / in_stall    mode, key, handle
// out      out_valid / out_stall  status, position, stored_handle, entry_count
// cfg      cfg_valid / cfg_ready  cfg_capacity
//
// One request at a time. Search makes halving steps over the entries held,
// each a RAM read then a compare, followed by one end check and one decide
// step. Insert and remove then move one entry per cycle through the single
// RAM port pair, then drain the pending write. The longest request is a
// remove of the lowest key from a full table.
// Reset empties the table and sets capacity to 64; no clearing pass is needed.
// A result waiting on out_stall sits in the output register while the next
// request is taken; the sequencer holds only if a second result is ready.
//
// Top level; depends on skt_pkg, skt_ctrl and skt_ram.
module sorted_key_table import skt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [KEY_W-1:0]    key,
	input  logic [HANDLE_W-1:0] handle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [PORT_W-1:0]   position,
	output logic [HANDLE_W-1:0] stored_handle,
	output logic [PORT_W-1:0]   entry_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_W-1:0]    cfg_capacity
);

	logic [CAP_W-1:0]   cap_q;
	mem_req_t           mem_req;
	logic [ENTRY_W-1:0] mem_rdata;
	logic               res_valid, res_ready;
	result_t            res;
	logic               out_valid_q;
	result_t            out_q;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_capacity;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.key       (key),
		.handle    (handle),
		.capacity  (cap_q),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	skt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign position      = out_q.position;
	assign stored_handle = out_q.stored_handle;
	assign entry_count   = out_q.entry_count;

endmodule
